/* rtl/kfsp_pkg.sv */
`timescale 1ns / 1ps

package kfsp_pkg;

  // Path geometry
  localparam int KEY_SPAN    = 120;
  localparam int COORD_WIDTH = 16;
  localparam int NUM_POINTS  = 4;
  localparam int NUM_AXES    = 3;

  // Segment boundaries, in tenths of a frame
  localparam longint SPAN_3 = 3 * KEY_SPAN;
  localparam longint SPAN_4 = 4 * KEY_SPAN;
  localparam longint SPAN_6 = 6 * KEY_SPAN;

  // Input frame and parameter lookup
  localparam int FRAME_W     = 12;
  localparam int FRAME_IDX_W = $clog2(KEY_SPAN);
  localparam int TAB_DEPTH   = 2 ** FRAME_IDX_W;
  localparam int T_W         = 16;
  localparam int SEG_W       = 2;
  localparam int TAB_ENTRY_W = SEG_W + T_W;

  // Arithmetic widths
  localparam int H_W         = 3 * T_W + 3;
  localparam int BASIS_SHIFT = 24;
  localparam int BASIS_W     = H_W - BASIS_SHIFT;
  localparam int WEIGHT_W    = BASIS_W + 1;
  localparam int ACC_SHIFT   = 25;
  localparam int LIN_SHIFT   = ACC_SHIFT - T_W;
  localparam int PROD_W      = WEIGHT_W + COORD_WIDTH;
  localparam int ACC_W       = PROD_W + 2;
  localparam int RES_W       = ACC_W - ACC_SHIFT;

  localparam longint COORD_MAX  = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_MIN  = -(longint'(1) <<< (COORD_WIDTH - 1));
  localparam longint ROUND_HALF = longint'(1) <<< (ACC_SHIFT - 1);

  // Configuration map
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = NUM_AXES * COORD_WIDTH;

  localparam logic [CFG_IDX_W-1:0] REG_POINT0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_POINT1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_POINT2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_POINT3 = CFG_IDX_W'(3);

  // Segment codes
  localparam logic [SEG_W-1:0] SEG_LEAD  = 2'd0;
  localparam logic [SEG_W-1:0] SEG_CURVE = 2'd1;
  localparam logic [SEG_W-1:0] SEG_TAIL  = 2'd2;

  typedef logic signed [FRAME_W-1:0]     frame_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef coord_t [NUM_AXES-1:0]         xyz_t;
  typedef xyz_t [NUM_POINTS-1:0]         points_t;
  typedef logic signed [BASIS_W-1:0]     basis_t;
  typedef logic signed [WEIGHT_W-1:0]    weight_t;
  typedef logic signed [ACC_W-1:0]       sum_t;

  typedef logic [TAB_DEPTH-1:0][TAB_ENTRY_W-1:0] t_tab_t;

  // Per-point blend weights, scaled by 2^ACC_SHIFT
  typedef struct packed {
    logic                       vld;
    logic                       span;
    weight_t [NUM_POINTS-1:0]   w;
  } wgt_bus_t;

  // Per-axis accumulated sums, rounding offset included
  typedef struct packed {
    logic                     vld;
    logic                     span;
    sum_t [NUM_AXES-1:0]      sum;
  } sum_bus_t;

  // Segment and local parameter t for every frame of the span
  function automatic t_tab_t build_tab();
    t_tab_t           tab;
    longint           f10;
    longint           num;
    logic [SEG_W-1:0] seg;
    tab = '0;
    for (int i = 0; i < KEY_SPAN; i++) begin
      f10 = 10 * longint'(i);
      if (f10 < SPAN_3) begin
        seg = SEG_LEAD;
        num = (f10 <<< T_W) / SPAN_3;
      end else if (f10 < SPAN_6) begin
        seg = SEG_CURVE;
        num = ((f10 - SPAN_3) <<< T_W) / SPAN_3;
      end else begin
        seg = SEG_TAIL;
        num = ((f10 - SPAN_6) <<< T_W) / SPAN_4;
      end
      tab[i] = {seg, T_W'(num)};
    end
    return tab;
  endfunction

  localparam t_tab_t T_TAB = build_tab();

endpackage

/* rtl/kfsp_ifs.sv */
`timescale 1ns / 1ps

interface kfsp_frame_if;
  import kfsp_pkg::*;
  logic   valid;
  logic   ready;
  frame_t frame_key;
  modport source (output valid, output frame_key, input ready);
  modport sink (input valid, input frame_key, output ready);
endinterface

interface kfsp_pos_if;
  import kfsp_pkg::*;
  logic   valid;
  logic   ready;
  coord_t pos_x;
  coord_t pos_y;
  coord_t pos_z;
  logic   valid_res;
  modport source (output valid, output pos_x, output pos_y, output pos_z, output valid_res,
                  input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z, input valid_res,
                output ready);
endinterface

interface kfsp_cfg_if;
  import kfsp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/keyframe_spline_position.sv */
`timescale 1ns / 1ps

// Channel  Role   Payload                              Transfer
// -------  -----  -----------------------------------  ------------------
// cfg      sink   index, data (x,y,z Q8.8, x low)      valid && ready
// frame    sink   frame_key (signed 12)                valid && ready
// pos      source pos_x, pos_y, pos_z, valid_res       valid && ready
//
// One frame per cycle enters while pos is not stalled; a result passes through
// eight register stages: lookup, t^2, t^3, basis, weights, products, sum,
// round/saturate into the output register.
// cfg is always ready; keyframes and valid bits reset synchronously on rst.
// A stall on pos freezes every stage together; frame.ready follows the
// output register being empty or taken in the same cycle.

module keyframe_spline_position (
  input  logic       clk,
  input  logic       rst,
  kfsp_cfg_if.sink   cfg,
  kfsp_frame_if.sink frame,
  kfsp_pos_if.source pos
);
  import kfsp_pkg::*;

  logic                    adv;
  points_t                 points;
  wgt_bus_t                wgt;
  sum_bus_t                sums;

  logic signed [RES_W-1:0] res [NUM_AXES];
  coord_t [NUM_AXES-1:0]   sat_pos;

  logic                    out_vld;
  logic                    out_span;
  coord_t [NUM_AXES-1:0]   out_pos;

  // Advance the whole pipe unless a result waits untaken
  assign adv         = !out_vld || pos.ready;
  assign frame.ready = adv;

  kfsp_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .points (points)
  );

  kfsp_basis u_basis (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_vld    (frame.valid),
    .frame_key (frame.frame_key),
    .wgt       (wgt)
  );

  kfsp_blend u_blend (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .points (points),
    .wgt    (wgt),
    .sums   (sums)
  );

  // Stage 8: drop the fraction and clamp to the coordinate range
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      res[a] = RES_W'($signed(sums.sum[a]) >>> ACC_SHIFT);
      if (res[a] > RES_W'(COORD_MAX)) begin
        sat_pos[a] = COORD_WIDTH'(COORD_MAX);
      end else if (res[a] < RES_W'(COORD_MIN)) begin
        sat_pos[a] = COORD_WIDTH'(COORD_MIN);
      end else begin
        sat_pos[a] = COORD_WIDTH'(res[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= sums.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_span <= sums.span;
      out_pos  <= sat_pos;
    end
  end

  assign pos.valid     = out_vld;
  assign pos.valid_res = out_span;
  assign pos.pos_x     = out_pos[0];
  assign pos.pos_y     = out_pos[1];
  assign pos.pos_z     = out_pos[2];

  // Frames outside the span report the origin
  a_off_span_zero: assert property (@(posedge clk) disable iff (rst)
    pos.valid && !pos.valid_res |->
      (pos.pos_x == '0) && (pos.pos_y == '0) && (pos.pos_z == '0))
    else $error("out-of-span result with nonzero position");

endmodule

/* rtl/kfsp_regs.sv */
`timescale 1ns / 1ps

module kfsp_regs (
  input  logic             clk,
  input  logic             rst,
  kfsp_cfg_if.sink         cfg,
  output kfsp_pkg::points_t points
);
  import kfsp_pkg::*;

  points_t pts;

  // Always take a configuration transfer
  assign cfg.ready = 1'b1;
  assign points    = pts;

  // Write the addressed keyframe; drop writes beyond the map
  always_ff @(posedge clk) begin
    if (rst) begin
      pts <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_POINT0: pts[0] <= cfg.data;
        REG_POINT1: pts[1] <= cfg.data;
        REG_POINT2: pts[2] <= cfg.data;
        REG_POINT3: pts[3] <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/kfsp_basis.sv */
`timescale 1ns / 1ps

module kfsp_basis (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_vld,
  input  kfsp_pkg::frame_t   frame_key,
  output kfsp_pkg::wgt_bus_t wgt
);
  import kfsp_pkg::*;

  localparam logic signed [BASIS_W-1:0] BASIS_ONE = BASIS_W'(longint'(1) <<< BASIS_SHIFT);

  // Round a 48-fraction-bit basis value to 24 fraction bits, ties up
  function automatic basis_t round_basis(input logic signed [H_W-1:0] h);
    logic signed [H_W-1:0] r;
    r = h + (H_W'(1) <<< (BASIS_SHIFT - 1));
    return BASIS_W'(r >>> BASIS_SHIFT);
  endfunction

  logic [TAB_ENTRY_W-1:0] entry;
  logic                   in_span;

  logic                   s1_vld, s1_span;
  logic [SEG_W-1:0]       s1_seg;
  logic [T_W-1:0]         s1_t;

  logic                   s2_vld, s2_span;
  logic [SEG_W-1:0]       s2_seg;
  logic [T_W-1:0]         s2_t;
  logic [2*T_W-1:0]       s2_t2;

  logic                   s3_vld, s3_span;
  logic [SEG_W-1:0]       s3_seg;
  logic [T_W-1:0]         s3_t;
  logic [2*T_W-1:0]       s3_t2;
  logic [3*T_W-1:0]       s3_t3;

  logic signed [H_W-1:0]  h_t1, h_t2, h_t3, h_one;
  logic signed [H_W-1:0]  h00, h01, h10, h11;

  logic                   s4_vld, s4_span;
  logic [SEG_W-1:0]       s4_seg;
  logic [T_W-1:0]         s4_t;
  basis_t                 s4_a00, s4_a01, s4_a10, s4_a11;

  logic [T_W:0]           t_comp;
  weight_t                lin_lo, lin_hi;
  weight_t [NUM_POINTS-1:0] w_next;

  logic                   s5_vld, s5_span;
  weight_t [NUM_POINTS-1:0] s5_w;

  // Stage 1: range check and segment/t lookup
  assign entry   = T_TAB[frame_key[FRAME_IDX_W-1:0]];
  assign in_span = !frame_key[FRAME_W-1] &&
                   (frame_key[FRAME_W-2:0] < (FRAME_W-1)'(KEY_SPAN));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= in_vld;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_span <= in_span;
      s1_seg  <= entry[TAB_ENTRY_W-1:T_W];
      s1_t    <= entry[T_W-1:0];
    end
  end

  // Stage 2: square t
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_span <= s1_span;
      s2_seg  <= s1_seg;
      s2_t    <= s1_t;
      s2_t2   <= s1_t * s1_t;
    end
  end

  // Stage 3: cube t
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_span <= s2_span;
      s3_seg  <= s2_seg;
      s3_t    <= s2_t;
      s3_t2   <= s2_t2;
      s3_t3   <= s2_t2 * s2_t;
    end
  end

  // Stage 4: Hermite basis at 48 fraction bits, rounded to 24
  always_comb begin
    h_t3  = H_W'(s3_t3);
    h_t2  = H_W'({s3_t2, {T_W{1'b0}}});
    h_t1  = H_W'({s3_t, {2*T_W{1'b0}}});
    h_one = H_W'(1) <<< (3 * T_W);
    h00   = (h_t3 <<< 1) - (h_t2 <<< 1) - h_t2 + h_one;
    h01   = (h_t2 <<< 1) + h_t2 - (h_t3 <<< 1);
    h10   = h_t3 - (h_t2 <<< 1) + h_t1;
    h11   = h_t3 - h_t2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_span <= s3_span;
      s4_seg  <= s3_seg;
      s4_t    <= s3_t;
      s4_a00  <= round_basis(h00);
      s4_a01  <= round_basis(h01);
      s4_a10  <= round_basis(h10);
      s4_a11  <= round_basis(h11);
    end
  end

  // Stage 5: fold basis or linear blend into one weight per keyframe
  always_comb begin
    t_comp = (T_W+1)'(1) << T_W;
    t_comp = t_comp - {1'b0, s4_t};
    lin_lo = WEIGHT_W'(t_comp) <<< LIN_SHIFT;
    lin_hi = WEIGHT_W'(s4_t) <<< LIN_SHIFT;
    w_next = '0;
    if (s4_span) begin
      case (s4_seg)
        SEG_LEAD: begin
          w_next[0] = lin_lo;
          w_next[1] = lin_hi;
        end
        SEG_CURVE: begin
          w_next[0] = -WEIGHT_W'(s4_a10);
          w_next[1] = (WEIGHT_W'(s4_a00) <<< 1) - WEIGHT_W'(s4_a11);
          w_next[2] = (WEIGHT_W'(s4_a01) <<< 1) + WEIGHT_W'(s4_a10);
          w_next[3] = WEIGHT_W'(s4_a11);
        end
        SEG_TAIL: begin
          w_next[2] = lin_lo;
          w_next[3] = lin_hi;
        end
        default: w_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_span <= s4_span;
      s5_w    <= w_next;
    end
  end

  always_comb begin
    wgt.vld  = s5_vld;
    wgt.span = s5_span;
    wgt.w    = s5_w;
  end

  // h00 + h01 is exactly one, so the rounded pair sums to one or one plus a tie bump
  a_basis_unity: assert property (@(posedge clk) disable iff (rst)
    s4_vld && s4_span && (s4_seg == SEG_CURVE) |->
      ((s4_a00 + s4_a01) == BASIS_ONE) || ((s4_a00 + s4_a01) == BASIS_ONE + 1))
    else $error("rounded Hermite basis lost partition of unity");

endmodule

/* rtl/kfsp_blend.sv */
`timescale 1ns / 1ps

module kfsp_blend (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  kfsp_pkg::points_t  points,
  input  kfsp_pkg::wgt_bus_t wgt,
  output kfsp_pkg::sum_bus_t sums
);
  import kfsp_pkg::*;

  logic                     s6_vld, s6_span;
  logic signed [PROD_W-1:0] prod [NUM_AXES][NUM_POINTS];

  sum_t [NUM_AXES-1:0]      sum_next;
  logic                     s7_vld, s7_span;
  sum_t [NUM_AXES-1:0]      s7_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
      s7_vld <= 1'b0;
    end else if (adv) begin
      s6_vld <= wgt.vld;
      s7_vld <= s6_vld;
    end
  end

  // Stage 6: weight times coordinate, one product per axis and keyframe
  always_ff @(posedge clk) begin
    if (adv) begin
      s6_span <= wgt.span;
      for (int a = 0; a < NUM_AXES; a++) begin
        for (int p = 0; p < NUM_POINTS; p++) begin
          prod[a][p] <= $signed(wgt.w[p]) * $signed(points[p][a]);
        end
      end
    end
  end

  // Stage 7: add the products and the rounding offset
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      sum_next[a] = ACC_W'(prod[a][0]) + ACC_W'(prod[a][1]) + ACC_W'(prod[a][2])
                  + ACC_W'(prod[a][3]) + ACC_W'(ROUND_HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_span <= s6_span;
      s7_sum  <= sum_next;
    end
  end

  always_comb begin
    sums.vld  = s7_vld;
    sums.span = s7_span;
    sums.sum  = s7_sum;
  end

  // Zeroed weights must leave only the rounding offset
  a_span_sum: assert property (@(posedge clk) disable iff (rst)
    s7_vld && !s7_span |->
      (s7_sum[0] == ACC_W'(ROUND_HALF)) && (s7_sum[1] == ACC_W'(ROUND_HALF)) &&
      (s7_sum[2] == ACC_W'(ROUND_HALF)))
    else $error("out-of-span item carried a nonzero sum");

endmodule
